// ===== hdl/gcu_pkg.sv =====
package gcu_pkg;

  // field widths
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned FREQ_W     = 14;
  localparam int unsigned FNOM_W     = 13;
  localparam int unsigned SPEED_W    = 14;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // shared datapath widths
  localparam int unsigned MUL_A_W    = 16;
  localparam int unsigned MUL_B_W    = 20;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned DIVIDEND_W = PROD_W + 1;
  localparam int unsigned DIVISOR_W  = 20;
  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned CNT_W      = $clog2(QUOT_W);

  // fixed-point constants
  localparam logic [SPEED_W-1:0]   SPEED_FULL   = 14'd10000;
  localparam logic [FREQ_W-1:0]    FREQ_MAX     = 14'd16383;
  localparam logic [VOLT_W-1:0]    VOLT_MAX     = 16'd65535;
  localparam logic [VOLT_W-1:0]    FAULT_STEP   = 16'd2000;
  localparam logic [VOLT_W-1:0]    OVER_NO_PROT = 16'd34000;
  localparam logic [VOLT_W-1:0]    UNDER_NO_PROT = 16'd16000;
  localparam logic [TIMER_W-1:0]   TIMER_MAX    = 16'd65535;
  localparam logic [MUL_B_W-1:0]   BASE_PCT     = 20'd95;
  localparam logic [MUL_B_W-1:0]   SPAN_PCT     = 20'd5;
  localparam logic [DIVISOR_W-1:0] PCT_FULL     = 20'd100;
  localparam logic [DIVIDEND_W-1:0] PCT_HALF    = 37'd50;
  localparam logic [DIVISOR_W-1:0] FREQ_DIV     = 20'd10000;
  localparam logic [DIVIDEND_W-1:0] FREQ_ROUND  = 37'd5000;

  // reset values of the registers
  localparam logic [VOLT_W-1:0]  RST_NOM_V   = 16'd28000;
  localparam logic [FNOM_W-1:0]  RST_NOM_F   = 13'd0;
  localparam logic [SPEED_W-1:0] RST_MIN_SPD = 14'd0;
  localparam logic [VOLT_W-1:0]  RST_OVER    = 16'd32000;
  localparam logic [VOLT_W-1:0]  RST_UNDER   = 16'd24000;
  localparam logic [TIMER_W-1:0] RST_DELAY   = 16'd100;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_FAIL  = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_UNDER = 2'd3
  } fault_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOM_VOLT  = 3'd0,
    REG_NOM_FREQ  = 3'd1,
    REG_MIN_SPEED = 3'd2,
    REG_OVER_LIM  = 3'd3,
    REG_UNDER_LIM = 3'd4,
    REG_DELAY     = 3'd5,
    REG_PROT      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [VOLT_W-1:0]  nominal_voltage_mv;
    logic [FNOM_W-1:0]  nominal_freq_dhz;
    logic [SPEED_W-1:0] min_speed_cpct;
    logic [VOLT_W-1:0]  overvolt_limit_mv;
    logic [VOLT_W-1:0]  undervolt_limit_mv;
    logic [TIMER_W-1:0] trip_delay_ms;
    logic               protection_present;
  } cfg_t;

endpackage

// ===== hdl/gcu_in_if.sv =====
interface gcu_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [gcu_pkg::SPEED_W-1:0]  engine_speed_cpct;
  logic [gcu_pkg::TICK_W-1:0]   tick_ms;
  logic [1:0]                   fault_code;

  modport source (output valid, operation, engine_speed_cpct, tick_ms, fault_code,
                  input ready);
  modport sink   (input valid, operation, engine_speed_cpct, tick_ms, fault_code,
                  output ready);
endinterface

// ===== hdl/gcu_out_if.sv =====
interface gcu_out_if;
  logic                        valid;
  logic                        ready;
  logic                        online;
  logic [gcu_pkg::VOLT_W-1:0]  voltage_mv;
  logic [gcu_pkg::FREQ_W-1:0]  frequency_dhz;
  logic                        trip_latched;

  modport source (output valid, online, voltage_mv, frequency_dhz, trip_latched,
                  input ready);
  modport sink   (input valid, online, voltage_mv, frequency_dhz, trip_latched,
                  output ready);
endinterface

// ===== hdl/gcu_cfg_if.sv =====
interface gcu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gcu_pkg::CFG_IDX_W-1:0]   index;
  logic [gcu_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/gcu_cfg_regs.sv =====
module gcu_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  gcu_cfg_if.sink       cfg_i,
  output gcu_pkg::cfg_t cfg_o
);

  gcu_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (gcu_pkg::reg_idx_e'(cfg_i.index))
        gcu_pkg::REG_NOM_VOLT:  cfg_d.nominal_voltage_mv = cfg_i.data;
        gcu_pkg::REG_NOM_FREQ:  cfg_d.nominal_freq_dhz   = cfg_i.data[gcu_pkg::FNOM_W-1:0];
        gcu_pkg::REG_MIN_SPEED: cfg_d.min_speed_cpct     = cfg_i.data[gcu_pkg::SPEED_W-1:0];
        gcu_pkg::REG_OVER_LIM:  cfg_d.overvolt_limit_mv  = cfg_i.data;
        gcu_pkg::REG_UNDER_LIM: cfg_d.undervolt_limit_mv = cfg_i.data;
        gcu_pkg::REG_DELAY:     cfg_d.trip_delay_ms      = cfg_i.data;
        gcu_pkg::REG_PROT:      cfg_d.protection_present = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nominal_voltage_mv <= gcu_pkg::RST_NOM_V;
      cfg_q.nominal_freq_dhz   <= gcu_pkg::RST_NOM_F;
      cfg_q.min_speed_cpct     <= gcu_pkg::RST_MIN_SPD;
      cfg_q.overvolt_limit_mv  <= gcu_pkg::RST_OVER;
      cfg_q.undervolt_limit_mv <= gcu_pkg::RST_UNDER;
      cfg_q.trip_delay_ms      <= gcu_pkg::RST_DELAY;
      cfg_q.protection_present <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/gcu_div.sv =====
// restoring divider, one quotient bit per cycle
// the caller guarantees the quotient fits in QUOT_W bits
module gcu_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [gcu_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [gcu_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                             done_o,
  output logic [gcu_pkg::QUOT_W-1:0]       quotient_o
);

  localparam int unsigned RW = gcu_pkg::DIVISOR_W;
  localparam int unsigned QW = gcu_pkg::QUOT_W;

  logic [RW-1:0]            rem_q, rem_d;
  logic [QW-1:0]            shf_q, shf_d;
  logic [RW-1:0]            dsr_q, dsr_d;
  logic [gcu_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [RW:0]              trial;
  logic                     fits;

  assign trial      = {rem_q, shf_q[QW-1]};
  assign fits       = trial >= {1'b0, dsr_q};
  assign done_o     = done_q;
  assign quotient_o = shf_q;

  always_comb begin
    rem_d  = rem_q;
    shf_d  = shf_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[QW+RW-1:QW];
      shf_d  = dividend_i[QW-1:0];
      dsr_d  = divisor_i;
      cnt_d  = gcu_pkg::CNT_W'(QW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? RW'(trial - {1'b0, dsr_q}) : trial[RW-1:0];
      shf_d = {shf_q[QW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    dsr_q <= dsr_d;
  end

endmodule

// ===== hdl/generator_source_with_gcu_trip.sv =====
// channel | dir | handshake     | word
// in_i    | in  | valid / ready | operation, engine_speed_cpct, tick_ms, fault_code
// out_o   | out | valid / ready | online, voltage_mv, frequency_dhz, trip_latched
// cfg_i   | in  | valid / ready | index, data (register write, always ready)
//
// an online tick makes up to two 16-step passes through the shared divider, each
// behind a registered product of the shared multiplier; a clear, a fail fault or
// an offline tick goes from ST_PROT straight to ST_OUT; the voltage pass is
// skipped at full factor and the frequency pass for a dc source
// rst_ni clears the sequencer, trip state and the stored voltage and frequency
// a new word is taken while a result waits on out_o; the next result holds in the
// sequencer until the output register frees up
module generator_source_with_gcu_trip (
  input  logic  clk_i,
  input  logic  rst_ni,
  gcu_in_if.sink    in_i,
  gcu_out_if.source out_o,
  gcu_cfg_if.sink   cfg_i
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PROT   = 9'b000000010,
    ST_MULV   = 9'b000000100,
    ST_STARTV = 9'b000001000,
    ST_WAITV  = 9'b000010000,
    ST_MULF   = 9'b000100000,
    ST_STARTF = 9'b001000000,
    ST_WAITF  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  localparam int unsigned VW = gcu_pkg::VOLT_W;
  localparam int unsigned FW = gcu_pkg::FREQ_W;
  localparam int unsigned SW = gcu_pkg::SPEED_W;
  localparam int unsigned TW = gcu_pkg::TIMER_W;

  gcu_pkg::cfg_t cfg;

  state_e state_q, state_d;

  // accepted word
  gcu_pkg::op_e    op_q;
  gcu_pkg::fault_e fault_q;
  logic [SW-1:0]   speed_q;
  logic [gcu_pkg::TICK_W-1:0] tick_q;

  // protection and history state
  logic [TW-1:0] timer_q, timer_d;
  logic          tripped_q, tripped_d;
  logic [VW-1:0] last_v_q, last_v_d;
  logic [FW-1:0] last_f_q, last_f_d;

  // work registers
  logic          online_q, online_d;
  logic [VW-1:0] v_q, v_d;
  logic [FW-1:0] f_q, f_d;
  logic [SW-1:0] den_q, den_d;
  logic [SW-1:0] num_q, num_d;
  logic [gcu_pkg::PROD_W-1:0] prod_q, prod_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          out_online_q, out_online_d;
  logic [VW-1:0] out_v_q, out_v_d;
  logic [FW-1:0] out_f_q, out_f_d;
  logic          out_trip_q, out_trip_d;

  // shared units
  logic [gcu_pkg::MUL_A_W-1:0]    mul_a;
  logic [gcu_pkg::MUL_B_W-1:0]    mul_b;
  logic [gcu_pkg::PROD_W-1:0]     mul_p;
  logic [gcu_pkg::MUL_B_W-1:0]    wsum;
  logic                           div_start;
  logic [gcu_pkg::DIVIDEND_W-1:0] div_dividend;
  logic [gcu_pkg::DIVISOR_W-1:0]  div_divisor;
  logic                           div_done;
  logic [gcu_pkg::QUOT_W-1:0]     div_quot;

  // per-tick decode
  logic          in_acc;
  logic          rpm_ok;
  logic          lv_high, lv_low, exceeded;
  logic [TW:0]   timer_sum;
  logic [TW-1:0] timer_sat;
  logic          trip_now;
  logic [SW-1:0] den_c, num_c;
  logic          full_c;
  logic          fnom_nz;
  logic [VW:0]   over_sum;
  logic [VW-1:0] v_fin;

  gcu_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  gcu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_i.ready          = (state_q == ST_IDLE);
  assign in_acc              = in_i.valid && in_i.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.online        = out_online_q;
  assign out_o.voltage_mv    = out_v_q;
  assign out_o.frequency_dhz = out_f_q;
  assign out_o.trip_latched  = out_trip_q;

  // protection on last tick's voltage
  assign rpm_ok    = speed_q >= cfg.min_speed_cpct;
  assign lv_high   = (last_v_q != '0) && (last_v_q > cfg.overvolt_limit_mv);
  assign lv_low    = (last_v_q != '0) && (last_v_q < cfg.undervolt_limit_mv) && rpm_ok;
  assign exceeded  = lv_high || lv_low || (fault_q == gcu_pkg::FAULT_OVER)
                     || (fault_q == gcu_pkg::FAULT_UNDER);
  assign timer_sum = {1'b0, timer_q} + (TW+1)'(tick_q);
  assign timer_sat = timer_sum[TW] ? gcu_pkg::TIMER_MAX : timer_sum[TW-1:0];
  assign trip_now  = timer_sat >= cfg.trip_delay_ms;

  // voltage ramp terms, only used when the speed is at or above the minimum
  assign den_c   = gcu_pkg::SPEED_FULL - cfg.min_speed_cpct;
  assign num_c   = speed_q - cfg.min_speed_cpct;
  assign full_c  = (cfg.min_speed_cpct >= gcu_pkg::SPEED_FULL) || (num_c >= den_c);
  assign fnom_nz = cfg.nominal_freq_dhz != '0;

  // shared multiplier: nominal * (95 den + 5 num), or nominal freq * speed
  assign wsum = gcu_pkg::MUL_B_W'(den_q) * gcu_pkg::BASE_PCT
              + gcu_pkg::MUL_B_W'(num_q) * gcu_pkg::SPAN_PCT;

  always_comb begin
    if (state_q == ST_MULF) begin
      mul_a = gcu_pkg::MUL_A_W'(cfg.nominal_freq_dhz);
      mul_b = gcu_pkg::MUL_B_W'(speed_q);
    end else begin
      mul_a = cfg.nominal_voltage_mv;
      mul_b = wsum;
    end
  end

  assign mul_p = gcu_pkg::PROD_W'(mul_a) * gcu_pkg::PROD_W'(mul_b);

  // shared divider: rounded voltage ratio or frequency scaling
  always_comb begin
    if (state_q == ST_STARTF) begin
      div_dividend = gcu_pkg::DIVIDEND_W'(prod_q) + gcu_pkg::FREQ_ROUND;
      div_divisor  = gcu_pkg::FREQ_DIV;
    end else begin
      div_dividend = gcu_pkg::DIVIDEND_W'(prod_q)
                   + gcu_pkg::DIVIDEND_W'(den_q) * gcu_pkg::PCT_HALF;
      div_divisor  = gcu_pkg::DIVISOR_W'(den_q) * gcu_pkg::PCT_FULL;
    end
  end

  // fault injection overrides the online voltage
  assign over_sum = {1'b0, cfg.overvolt_limit_mv} + {1'b0, gcu_pkg::FAULT_STEP};

  always_comb begin
    v_fin = v_q;
    if (online_q) begin
      unique case (fault_q)
        gcu_pkg::FAULT_OVER: begin
          if (cfg.protection_present) begin
            v_fin = over_sum[VW] ? gcu_pkg::VOLT_MAX : over_sum[VW-1:0];
          end else begin
            v_fin = gcu_pkg::OVER_NO_PROT;
          end
        end
        gcu_pkg::FAULT_UNDER: begin
          if (cfg.protection_present) begin
            v_fin = (cfg.undervolt_limit_mv >= gcu_pkg::FAULT_STEP)
                  ? cfg.undervolt_limit_mv - gcu_pkg::FAULT_STEP : '0;
          end else begin
            v_fin = gcu_pkg::UNDER_NO_PROT;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    timer_d      = timer_q;
    tripped_d    = tripped_q;
    last_v_d     = last_v_q;
    last_f_d     = last_f_q;
    online_d     = online_q;
    v_d          = v_q;
    f_d          = f_q;
    den_d        = den_q;
    num_d        = num_q;
    prod_d       = prod_q;
    div_start    = 1'b0;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_online_d = out_online_q;
    out_v_d      = out_v_q;
    out_f_d      = out_f_q;
    out_trip_d   = out_trip_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_PROT;
        end
      end
      ST_PROT: begin
        online_d = 1'b0;
        v_d      = '0;
        f_d      = '0;
        state_d  = ST_OUT;
        if (op_q == gcu_pkg::OP_CLEAR) begin
          // unlatch and report the previous tick's values
          tripped_d = 1'b0;
          timer_d   = '0;
          v_d       = last_v_q;
          f_d       = last_f_q;
        end else if (fault_q != gcu_pkg::FAULT_FAIL) begin
          if (cfg.protection_present && !tripped_q) begin
            if (exceeded) begin
              timer_d   = timer_sat;
              tripped_d = trip_now;
            end else begin
              timer_d = '0;
            end
          end
          online_d = rpm_ok && !tripped_d;
          if (online_d) begin
            den_d = den_c;
            num_d = num_c;
            v_d   = cfg.nominal_voltage_mv;
            f_d   = last_f_q;
            if (!full_c) begin
              state_d = ST_MULV;
            end else if (fnom_nz) begin
              state_d = ST_MULF;
            end
          end
        end
      end
      ST_MULV: begin
        prod_d  = mul_p;
        state_d = ST_STARTV;
      end
      ST_STARTV: begin
        div_start = 1'b1;
        state_d   = ST_WAITV;
      end
      ST_WAITV: begin
        if (div_done) begin
          v_d     = div_quot;
          state_d = fnom_nz ? ST_MULF : ST_OUT;
        end
      end
      ST_MULF: begin
        prod_d  = mul_p;
        state_d = ST_STARTF;
      end
      ST_STARTF: begin
        div_start = 1'b1;
        state_d   = ST_WAITF;
      end
      ST_WAITF: begin
        if (div_done) begin
          f_d     = (div_quot > gcu_pkg::QUOT_W'(gcu_pkg::FREQ_MAX))
                  ? gcu_pkg::FREQ_MAX : div_quot[FW-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_online_d = online_q;
          out_v_d      = v_fin;
          out_f_d      = f_q;
          out_trip_d   = tripped_q;
          last_v_d     = v_fin;
          last_f_d     = f_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timer_q     <= '0;
      tripped_q   <= 1'b0;
      last_v_q    <= '0;
      last_f_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      timer_q     <= timer_d;
      tripped_q   <= tripped_d;
      last_v_q    <= last_v_d;
      last_f_q    <= last_f_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= gcu_pkg::op_e'(in_i.operation);
      fault_q <= gcu_pkg::fault_e'(in_i.fault_code);
      speed_q <= in_i.engine_speed_cpct;
      tick_q  <= in_i.tick_ms;
    end
    online_q     <= online_d;
    v_q          <= v_d;
    f_q          <= f_d;
    den_q        <= den_d;
    num_q        <= num_d;
    prod_q       <= prod_d;
    out_online_q <= out_online_d;
    out_v_q      <= out_v_d;
    out_f_q      <= out_f_d;
    out_trip_q   <= out_trip_d;
  end

endmodule
